FILE: rtl/core/sse_pkg.sv
// shared types and constants for the sprite script executor
package sse_pkg;

	localparam int DATA_W            = 16;
	localparam int PROP_COUNT        = 7;
	localparam int NEXT_PC_W         = 10;
	localparam int PROGRAM_BYTES_DEF = 1024;

	// instruction bytes
	localparam logic [7:0] OP_MOVE_ABS    = 8'h01;
	localparam logic [7:0] OP_MOVE_REL    = 8'h02;
	localparam logic [7:0] OP_SLEEP       = 8'hFF;
	localparam logic [7:0] OP_JUMP        = 8'hF0;
	localparam logic [7:0] OP_JUMP_EQ     = 8'hF1;
	localparam logic [7:0] OP_JUMP_NE     = 8'hF2;
	localparam logic [7:0] OP_JUMP_GT     = 8'hF3;
	localparam logic [7:0] OP_JUMP_GE     = 8'hF4;
	localparam logic [7:0] OP_JUMP_LT     = 8'hF5;
	localparam logic [7:0] OP_JUMP_LE     = 8'hF6;
	localparam logic [7:0] OP_LOAD_A      = 8'hE0;
	localparam logic [7:0] OP_LOAD_B      = 8'hE1;
	localparam logic [7:0] OP_LOAD_PROP_A = 8'hE2;
	localparam logic [7:0] OP_LOAD_PROP_B = 8'hE3;
	localparam logic [7:0] OP_STORE_A     = 8'hE4;
	localparam logic [7:0] OP_STORE_B     = 8'hE5;
	localparam logic [7:0] OP_ADD         = 8'hD0;
	localparam logic [7:0] OP_SUB         = 8'hD1;
	localparam logic [7:0] OP_MUL         = 8'hD2;
	localparam logic [7:0] OP_DIV         = 8'hD3;
	localparam logic [7:0] OP_MOD         = 8'hD4;

	// one instruction transfer
	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] arg_first;
		logic [7:0] arg_second;
		logic [7:0] arg_third;
		logic [7:0] arg_fourth;
	} item_t;

	// one result transfer
	typedef struct packed {
		logic [NEXT_PC_W-1:0] next_pc;
		logic [DATA_W-1:0]    reg_a_out;
		logic [DATA_W-1:0]    pos_x;
		logic [DATA_W-1:0]    pos_y;
		logic [DATA_W-1:0]    size_w;
		logic [DATA_W-1:0]    size_h;
		logic [DATA_W-1:0]    colour_out;
		logic [DATA_W-1:0]    visible_out;
		logic [DATA_W-1:0]    kind_out;
		logic                 sleep_start;
		logic [DATA_W-1:0]    sleep_ticks;
		logic                 props_changed;
	} result_t;

	// request into the shared divider
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/core/sprite_script_executor.sv
// sprite script executor: runs one bytecode instruction per input transfer
// a result is registered from the execute state, or for divide and modulo from the divider wait state
// one instruction at a time: no new input is taken until its result is committed; divide and modulo
// use the shared 16-bit divider that resolves one quotient bit per cycle
// reset: counter, registers A and B and all seven properties clear to zero at once
module sprite_script_executor #(
	parameter int PROGRAM_BYTES = sse_pkg::PROGRAM_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sse_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output sse_pkg::result_t result
);
	import sse_pkg::*;

	localparam int PC_W = $clog2(PROGRAM_BYTES);

	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FIVE  = 3'd5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV
	} state_t;

	state_t            state_q;
	item_t             item_q;
	logic [PC_W-1:0]   pc_q;
	logic [DATA_W-1:0] reg_a_q;
	logic [DATA_W-1:0] reg_b_q;
	logic [DATA_W-1:0] prop_q [PROP_COUNT];
	logic              result_valid_q;
	result_t           result_q;

	div_req_t          div_req;
	div_stat_t         div_stat;
	logic [DATA_W-1:0] div_quo;
	logic [DATA_W-1:0] div_rem;

	logic              is_div;
	logic              out_free;
	logic              commit;
	logic [DATA_W-1:0] val_first;
	logic [DATA_W-1:0] val_second;
	logic              idx_ok;
	logic [DATA_W-1:0] prop_rd;
	logic [2*DATA_W-1:0] product;
	logic              a_eq_b;
	logic              a_lt_b;
	logic              jump;
	logic [2:0]        len;
	logic [PC_W:0]     pc_sum;
	logic [PC_W:0]     pc_wrapped;
	logic [PC_W-1:0]   pc_n;
	logic [PC_W+NEXT_PC_W-1:0] pc_ext;
	logic [DATA_W-1:0] reg_a_n;
	logic [DATA_W-1:0] reg_b_n;
	logic [DATA_W-1:0] prop_n [PROP_COUNT];
	logic              slept;
	logic [DATA_W-1:0] ticks;
	logic              changed;

	// shared iterative divider for divide and modulo
	sse_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign is_div           = (item_q.opcode == OP_DIV) || (item_q.opcode == OP_MOD);
	assign div_req.start    = (state_q == S_EXEC) && is_div;
	assign div_req.dividend = reg_a_q;
	assign div_req.divisor  = reg_b_q;

	// output register is free when empty or drained this cycle
	assign out_free = !result_valid_q || !result_stall;
	assign commit   = out_free && (((state_q == S_EXEC) && !is_div) ||
		((state_q == S_DIV) && div_stat.done));

	// operand decode and property read
	assign val_first  = {item_q.arg_first, item_q.arg_second};
	assign val_second = {item_q.arg_third, item_q.arg_fourth};
	assign idx_ok     = (item_q.arg_first < 8'(PROP_COUNT));
	assign prop_rd    = idx_ok ? prop_q[item_q.arg_first[2:0]] : '0;
	assign product    = reg_a_q * reg_b_q;
	assign a_eq_b     = (reg_a_q == reg_b_q);
	assign a_lt_b     = (reg_a_q < reg_b_q);

	// instruction execute: next architectural state
	always_comb begin
		reg_a_n = reg_a_q;
		reg_b_n = reg_b_q;
		for (int i = 0; i < PROP_COUNT; i++) begin
			prop_n[i] = prop_q[i];
		end
		jump    = 1'b0;
		len     = LEN_ONE;
		slept   = 1'b0;
		ticks   = '0;
		changed = 1'b0;
		case (item_q.opcode)
			OP_MOVE_ABS: begin
				prop_n[0] = val_first;
				prop_n[1] = val_second;
				len       = LEN_FIVE;
			end
			OP_MOVE_REL: begin
				prop_n[0] = prop_q[0] + val_first;
				prop_n[1] = prop_q[1] + val_second;
				len       = LEN_FIVE;
			end
			OP_SLEEP: begin
				slept = 1'b1;
				ticks = val_first;
				len   = LEN_THREE;
			end
			OP_JUMP: jump = 1'b1;
			OP_JUMP_EQ: begin
				jump = a_eq_b;
				len  = LEN_TWO;
			end
			OP_JUMP_NE: begin
				jump = !a_eq_b;
				len  = LEN_TWO;
			end
			OP_JUMP_GT: begin
				jump = !a_lt_b && !a_eq_b;
				len  = LEN_TWO;
			end
			OP_JUMP_GE: begin
				jump = !a_lt_b;
				len  = LEN_TWO;
			end
			OP_JUMP_LT: begin
				jump = a_lt_b;
				len  = LEN_TWO;
			end
			OP_JUMP_LE: begin
				jump = a_lt_b || a_eq_b;
				len  = LEN_TWO;
			end
			OP_LOAD_A: begin
				reg_a_n = val_first;
				len     = LEN_THREE;
			end
			OP_LOAD_B: begin
				reg_b_n = val_first;
				len     = LEN_THREE;
			end
			OP_LOAD_PROP_A: begin
				reg_a_n = prop_rd;
				len     = LEN_TWO;
			end
			OP_LOAD_PROP_B: begin
				reg_b_n = prop_rd;
				len     = LEN_TWO;
			end
			OP_STORE_A: begin
				if (idx_ok) begin
					prop_n[item_q.arg_first[2:0]] = reg_a_q;
				end
				changed = 1'b1;
				len     = LEN_TWO;
			end
			OP_STORE_B: begin
				if (idx_ok) begin
					prop_n[item_q.arg_first[2:0]] = reg_b_q;
				end
				changed = 1'b1;
				len     = LEN_TWO;
			end
			OP_ADD: reg_a_n = reg_a_q + reg_b_q;
			OP_SUB: reg_a_n = reg_a_q - reg_b_q;
			OP_MUL: reg_a_n = product[DATA_W-1:0];
			OP_DIV: reg_a_n = div_quo;
			OP_MOD: reg_a_n = div_rem;
			default: len = LEN_ONE;
		endcase
	end

	// program counter advance with a single wrap correction
	assign pc_sum     = {1'b0, pc_q} + (PC_W+1)'(len);
	assign pc_wrapped = (pc_sum >= (PC_W+1)'(PROGRAM_BYTES)) ?
		pc_sum - (PC_W+1)'(PROGRAM_BYTES) : pc_sum;
	assign pc_n       = jump ? PC_W'(item_q.arg_first) : pc_wrapped[PC_W-1:0];
	assign pc_ext     = (PC_W+NEXT_PC_W)'(pc_n);

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// sequencer, architectural state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pc_q           <= '0;
			reg_a_q        <= '0;
			reg_b_q        <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < PROP_COUNT; i++) begin
				prop_q[i] <= '0;
			end
		end else begin
			if (commit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (is_div) begin
						state_q <= S_DIV;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_stat.done && out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				pc_q    <= pc_n;
				reg_a_q <= reg_a_n;
				reg_b_q <= reg_b_n;
				for (int i = 0; i < PROP_COUNT; i++) begin
					prop_q[i] <= prop_n[i];
				end
			end
		end
	end

	// instruction capture and result payload
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && item_valid) begin
			item_q <= item;
		end
		if (commit) begin
			result_q.next_pc       <= pc_ext[NEXT_PC_W-1:0];
			result_q.reg_a_out     <= reg_a_n;
			result_q.pos_x         <= prop_n[0];
			result_q.pos_y         <= prop_n[1];
			result_q.size_w        <= prop_n[2];
			result_q.size_h        <= prop_n[3];
			result_q.colour_out    <= prop_n[4];
			result_q.visible_out   <= prop_n[5];
			result_q.kind_out      <= prop_n[6];
			result_q.sleep_start   <= slept;
			result_q.sleep_ticks   <= ticks;
			result_q.props_changed <= changed;
		end
	end

`ifndef SYNTHESIS
	// divider is working or finished whenever the sequencer waits on it
	a_div_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_stat.busy || div_stat.done))
		else $error("sequencer waits on an idle divider");

	// counter always stays inside the program
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, pc_q} < (PC_W+1)'(PROGRAM_BYTES)))
		else $error("program counter outside the program");

	// a delay count only accompanies a sleep
	a_sleep_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.sleep_start) |-> (result.sleep_ticks == '0))
		else $error("delay count without sleep");

	// a result is only loaded once the previous one has gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |-> !commit)
		else $error("result register overwritten while stalled");
`endif

endmodule

FILE: rtl/core/sse_divider.sv
// iterative restoring divider, one quotient bit per cycle
module sse_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sse_pkg::div_req_t          req,
	output sse_pkg::div_stat_t         stat,
	output logic [sse_pkg::DATA_W-1:0] quotient,
	output logic [sse_pkg::DATA_W-1:0] remainder
);
	import sse_pkg::*;

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] diff;

	// trial subtraction of the divisor from the shifted partial remainder
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	// step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= CNT_W'(DATA_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// partial remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			if (diff[DATA_W+1]) begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end else begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: tb/sprite_script_executor_tb.sv
// self-checking testbench for the sprite script executor
module sprite_script_executor_tb;
	import sse_pkg::*;

	localparam int PROG_BYTES     = PROGRAM_BYTES_DEF;
	localparam int TOTAL_ITEMS    = 1950;
	localparam int WRAP_RUN_AT    = 800;
	localparam int WRAP_RUN_LEN   = 230;
	localparam int DRAIN_EVERY    = 700;
	localparam int HOLD_AT        = 400;
	localparam int HOLD_CYCLES    = 80;
	localparam int CALM_FROM      = 1100;
	localparam int CALM_TO        = 1400;
	localparam int TAIL_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 50;

	typedef struct {
		item_t ins;
		bit    drain;
	} pending_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// instruction stream and expected architectural state after each step
	pending_t program_queue[$];
	result_t  expected_state[$];

	// predictor copy of the executor state
	logic [9:0]  cur_pc;
	logic [15:0] acc_a;
	logic [15:0] acc_b;
	logic [15:0] obj_props [0:PROP_COUNT-1];

	int items_accepted  = 0;
	int results_seen    = 0;
	int mismatch_count  = 0;
	int jumps_taken     = 0;
	int pc_wraps        = 0;
	int zero_divisors   = 0;
	int stray_prop_refs = 0;
	int hold_left       = 0;
	bit hold_done       = 1'b0;

	sprite_script_executor DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #4 clk = ~clk;

	// single reset pulse at start of run
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("mismatch on %s at result %0d: got %h expected %h",
				what, results_seen, got, want);
	endtask

	// executes one instruction on the predictor state
	function automatic result_t execute_instruction(input item_t ins);
		result_t     r;
		logic [15:0] v1;
		logic [15:0] v2;
		int          len;
		bit          take;
		v1   = {ins.arg_first, ins.arg_second};
		v2   = {ins.arg_third, ins.arg_fourth};
		len  = 1;
		take = 1'b0;
		r    = '0;
		case (ins.opcode)
			OP_MOVE_ABS: begin
				obj_props[0] = v1;
				obj_props[1] = v2;
				len = 5;
			end
			OP_MOVE_REL: begin
				obj_props[0] = obj_props[0] + v1;
				obj_props[1] = obj_props[1] + v2;
				len = 5;
			end
			OP_SLEEP: begin
				r.sleep_start = 1'b1;
				r.sleep_ticks = v1;
				len = 3;
			end
			OP_JUMP:    take = 1'b1;
			OP_JUMP_EQ: begin take = acc_a == acc_b; len = 2; end
			OP_JUMP_NE: begin take = acc_a != acc_b; len = 2; end
			OP_JUMP_GT: begin take = acc_a >  acc_b; len = 2; end
			OP_JUMP_GE: begin take = acc_a >= acc_b; len = 2; end
			OP_JUMP_LT: begin take = acc_a <  acc_b; len = 2; end
			OP_JUMP_LE: begin take = acc_a <= acc_b; len = 2; end
			OP_LOAD_A:  begin acc_a = v1; len = 3; end
			OP_LOAD_B:  begin acc_b = v1; len = 3; end
			OP_LOAD_PROP_A, OP_LOAD_PROP_B: begin
				if (ins.arg_first < PROP_COUNT)
					v2 = obj_props[ins.arg_first[2:0]];
				else begin
					v2 = '0;
					stray_prop_refs++;
				end
				if (ins.opcode == OP_LOAD_PROP_A)
					acc_a = v2;
				else
					acc_b = v2;
				len = 2;
			end
			OP_STORE_A, OP_STORE_B: begin
				if (ins.arg_first < PROP_COUNT)
					obj_props[ins.arg_first[2:0]] = (ins.opcode == OP_STORE_A) ? acc_a : acc_b;
				else
					stray_prop_refs++;
				r.props_changed = 1'b1;
				len = 2;
			end
			OP_ADD: acc_a = acc_a + acc_b;
			OP_SUB: acc_a = acc_a - acc_b;
			OP_MUL: acc_a = acc_a * acc_b;
			OP_DIV: begin
				if (acc_b == 0) begin
					acc_a = 16'hFFFF;
					zero_divisors++;
				end else
					acc_a = acc_a / acc_b;
			end
			OP_MOD: begin
				// zero divisor leaves A untouched
				if (acc_b == 0)
					zero_divisors++;
				else
					acc_a = acc_a % acc_b;
			end
			default: ;
		endcase
		if (take) begin
			cur_pc = 10'(int'(ins.arg_first) % PROG_BYTES);
			jumps_taken++;
		end else begin
			if (int'(cur_pc) + len >= PROG_BYTES)
				pc_wraps++;
			cur_pc = 10'((int'(cur_pc) + len) % PROG_BYTES);
		end
		r.next_pc     = cur_pc;
		r.reg_a_out   = acc_a;
		r.pos_x       = obj_props[0];
		r.pos_y       = obj_props[1];
		r.size_w      = obj_props[2];
		r.size_h      = obj_props[3];
		r.colour_out  = obj_props[4];
		r.visible_out = obj_props[5];
		r.kind_out    = obj_props[6];
		return r;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	// no idling during the calm stretch
	function automatic bit random_idle();
		if (items_accepted >= CALM_FROM && items_accepted < CALM_TO)
			return 1'b0;
		return $urandom_range(99) < 6;
	endfunction

	function automatic logic [7:0] unknown_opcode();
		logic [7:0] op;
		bit         known;
		do begin
			op = rand_byte();
			case (op)
				OP_MOVE_ABS, OP_MOVE_REL, OP_SLEEP, OP_JUMP, OP_JUMP_EQ, OP_JUMP_NE,
				OP_JUMP_GT, OP_JUMP_GE, OP_JUMP_LT, OP_JUMP_LE, OP_LOAD_A, OP_LOAD_B,
				OP_LOAD_PROP_A, OP_LOAD_PROP_B, OP_STORE_A, OP_STORE_B, OP_ADD,
				OP_SUB, OP_MUL, OP_DIV, OP_MOD: known = 1'b1;
				default: known = 1'b0;
			endcase
		end while (known);
		return op;
	endfunction

	task automatic queue_item(input logic [7:0] op, input logic [7:0] b1 = 8'h00,
			input logic [7:0] b2 = 8'h00, input logic [7:0] b3 = 8'h00,
			input logic [7:0] b4 = 8'h00);
		pending_t entry;
		entry.ins   = {op, b1, b2, b3, b4};
		// every so often the sender waits for all results first
		entry.drain = program_queue.size() != 0 && program_queue.size() % DRAIN_EVERY == 0;
		program_queue.push_back(entry);
	endtask

	function automatic logic [7:0] prop_index();
		if ($urandom_range(7) == 0)
			return 8'($urandom_range(255, 7));
		return 8'($urandom_range(PROP_COUNT - 1));
	endfunction

	// one short well-formed sequence, or noise
	task automatic queue_random_group();
		logic [15:0] v;
		logic [15:0] w;
		logic [7:0]  op;
		v = 16'($urandom);
		w = 16'($urandom);
		case ($urandom_range(9))
			0, 1: begin
				// compare then branch
				case ($urandom_range(3))
					0: w = v;
					1: w = v + 1;
					2: w = v - 1;
					default: ;
				endcase
				queue_item(OP_LOAD_A, v[15:8], v[7:0], rand_byte(), rand_byte());
				queue_item(OP_LOAD_B, w[15:8], w[7:0], rand_byte(), rand_byte());
				case ($urandom_range(6))
					0: op = OP_JUMP;
					1: op = OP_JUMP_EQ;
					2: op = OP_JUMP_NE;
					3: op = OP_JUMP_GT;
					4: op = OP_JUMP_GE;
					5: op = OP_JUMP_LT;
					default: op = OP_JUMP_LE;
				endcase
				queue_item(op, rand_byte(), rand_byte(), rand_byte(), rand_byte());
			end
			2, 3: begin
				// operands then arithmetic
				if ($urandom_range(9) == 0)
					w = '0;
				else if ($urandom_range(1) == 0)
					w = 16'($urandom_range(300, 1));
				queue_item(OP_LOAD_A, v[15:8], v[7:0], rand_byte(), rand_byte());
				queue_item(OP_LOAD_B, w[15:8], w[7:0], rand_byte(), rand_byte());
				repeat ($urandom_range(2, 1)) begin
					case ($urandom_range(4))
						0: op = OP_ADD;
						1: op = OP_SUB;
						2: op = OP_MUL;
						3: op = OP_DIV;
						default: op = OP_MOD;
					endcase
					queue_item(op, rand_byte(), rand_byte(), rand_byte(), rand_byte());
				end
			end
			4, 5: begin
				// property store then load back
				queue_item($urandom_range(1) ? OP_STORE_A : OP_STORE_B, prop_index(),
					rand_byte(), rand_byte(), rand_byte());
				queue_item($urandom_range(1) ? OP_LOAD_PROP_A : OP_LOAD_PROP_B, prop_index(),
					rand_byte(), rand_byte(), rand_byte());
			end
			6: begin
				case ($urandom_range(2))
					0: op = OP_MOVE_ABS;
					1: op = OP_MOVE_REL;
					default: op = OP_SLEEP;
				endcase
				queue_item(op, rand_byte(), rand_byte(), rand_byte(), rand_byte());
			end
			7: queue_item(unknown_opcode(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
			default: queue_item(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
		endcase
	endtask

	// stimulus: directed instructions, then random sequences
	initial begin : stimulus
		bit wrap_done;
		wrap_done = 1'b0;
		queue_item(OP_MOVE_ABS, 8'hFF, 8'hFF, 8'h00, 8'h00);
		queue_item(OP_MOVE_REL, 8'h00, 8'h01, 8'hFF, 8'hFF);
		queue_item(OP_SLEEP, 8'hFF, 8'hFF);
		queue_item(OP_LOAD_A, 8'h12, 8'h34);
		queue_item(OP_LOAD_B, 8'h00, 8'h00);
		queue_item(OP_DIV);
		queue_item(OP_MOD);
		queue_item(OP_LOAD_B, 8'h00, 8'h07);
		queue_item(OP_ADD);
		queue_item(OP_SUB);
		queue_item(OP_MUL);
		queue_item(OP_DIV);
		queue_item(OP_MOD);
		queue_item(OP_STORE_A, 8'h02);
		queue_item(OP_STORE_B, 8'hFF);
		queue_item(OP_LOAD_PROP_A, 8'h02);
		queue_item(OP_LOAD_PROP_B, 8'h07);
		queue_item(OP_JUMP, 8'hFF);
		queue_item(OP_JUMP_EQ, 8'h10);
		queue_item(OP_JUMP_NE, 8'h20);
		queue_item(OP_JUMP_GT, 8'h30);
		queue_item(OP_JUMP_GE, 8'h40);
		queue_item(OP_JUMP_LT, 8'h50);
		queue_item(OP_JUMP_LE, 8'h60);
		queue_item(unknown_opcode(), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		while (program_queue.size() < TOTAL_ITEMS) begin
			// long run without jumps so the counter wraps
			if (!wrap_done && program_queue.size() >= WRAP_RUN_AT) begin
				wrap_done = 1'b1;
				repeat (WRAP_RUN_LEN)
					queue_item($urandom_range(1) ? OP_MOVE_REL : OP_MOVE_ABS, rand_byte(),
						rand_byte(), rand_byte(), rand_byte());
			end
			queue_random_group();
		end
	end

	// instruction driver
	always @(posedge clk or negedge arst_n) begin : driver
		pending_t head;
		bit       offer;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else if (!item_valid || !item_stall) begin
			offer = 1'b0;
			if (program_queue.size() != 0 && !random_idle()) begin
				head  = program_queue[0];
				offer = !head.drain || (!item_valid && expected_state.size() == 0);
			end
			if (offer) begin
				head = program_queue.pop_front();
				item <= head.ins;
			end
			item_valid <= offer;
		end
	end

	// result receiver, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (!hold_done && items_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= random_idle();
			end
		end
	end

	// predict on each instruction transfer, check each result transfer
	always @(posedge clk) begin : monitor
		result_t want;
		if (!arst_n) begin
			cur_pc = '0;
			acc_a  = '0;
			acc_b  = '0;
			for (int i = 0; i < PROP_COUNT; i++)
				obj_props[i] = '0;
		end else begin
			if (item_valid && !item_stall) begin
				expected_state.push_back(execute_instruction(item));
				items_accepted++;
			end
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_state.size() == 0) begin
					report_mismatch("unexpected result", result.next_pc, '0);
				end else begin
					want = expected_state.pop_front();
					if (result.next_pc !== want.next_pc)
						report_mismatch("next_pc", result.next_pc, want.next_pc);
					if (result.reg_a_out !== want.reg_a_out)
						report_mismatch("reg_a_out", result.reg_a_out, want.reg_a_out);
					if (result.pos_x !== want.pos_x)
						report_mismatch("pos_x", result.pos_x, want.pos_x);
					if (result.pos_y !== want.pos_y)
						report_mismatch("pos_y", result.pos_y, want.pos_y);
					if (result.size_w !== want.size_w)
						report_mismatch("size_w", result.size_w, want.size_w);
					if (result.size_h !== want.size_h)
						report_mismatch("size_h", result.size_h, want.size_h);
					if (result.colour_out !== want.colour_out)
						report_mismatch("colour_out", result.colour_out, want.colour_out);
					if (result.visible_out !== want.visible_out)
						report_mismatch("visible_out", result.visible_out, want.visible_out);
					if (result.kind_out !== want.kind_out)
						report_mismatch("kind_out", result.kind_out, want.kind_out);
					if (result.sleep_start !== want.sleep_start)
						report_mismatch("sleep_start", result.sleep_start, want.sleep_start);
					if (result.sleep_ticks !== want.sleep_ticks)
						report_mismatch("sleep_ticks", result.sleep_ticks, want.sleep_ticks);
					if (result.props_changed !== want.props_changed)
						report_mismatch("props_changed", result.props_changed,
							want.props_changed);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("status: fail");
		$finish;
	end

	// end of run
	initial begin : run_control
		@(posedge arst_n);
		while (program_queue.size() != 0 || item_valid || expected_state.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_state.size() != 0)
			report_mismatch("results never delivered", expected_state.size(), '0);
		$display("ran %0d instructions and checked %0d results, %0d mismatches",
			items_accepted, results_seen, mismatch_count);
		$display("covered %0d taken jumps, %0d counter wraps, %0d zero divisors, %0d %s",
			jumps_taken, pc_wraps, zero_divisors, stray_prop_refs,
			"out-of-range property accesses");
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
